### hw/rtl/paged_memory_allocator_mmu_unit_assert.svh
// Assertion macros for the paged memory allocator unit.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef PAGED_MEMORY_ALLOCATOR_MMU_UNIT_ASSERT_SVH
`define PAGED_MEMORY_ALLOCATOR_MMU_UNIT_ASSERT_SVH

// Checked at every rising clock edge outside reset.
`define PMA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define PMA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/pma_pkg.sv
// Shared types and fixed field widths of the paged memory allocator unit.
// No dependencies.
package pma_pkg;

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_ALLOC = 2'd0;
    localparam cmd_t CMD_FREE  = 2'd1;
    localparam cmd_t CMD_READ  = 2'd2;
    localparam cmd_t CMD_WRITE = 2'd3;

    localparam int PID_W   = 5;
    localparam int ADDR_W  = 20;
    localparam int SIZE_W  = 21;
    localparam int BREAK_W = 21;
    localparam int DATA_W  = 8;
    // Width that holds any break plus any rounded request without overflow.
    localparam int SUM_W   = 26;

    localparam logic [BREAK_W-1:0] BREAK_RESET = 21'd1024;

endpackage

### hw/rtl/paged_memory_allocator_mmu_unit.sv
// Paged memory allocator unit: sequencer around four RAMs (owner, link, map, bytes).
// Allocate scans the owner RAM page by page (at most PHYS_PAGES pages), but a failure or a zero size
// skips the scan; free walks the page chain, then unmaps each walked page; read and write use the map.
// One request at a time; a stalled result holds the sequencer in its last state.
// Reset: asynchronous, active low; a clearing pass over max(RAM_BYTES, map depth, PHYS_PAGES)
// entries zeroes all RAMs before the first request is taken.
`include "paged_memory_allocator_mmu_unit_assert.svh"

module paged_memory_allocator_mmu_unit #(
    parameter int OFFSET_BITS = 10,
    parameter int PHYS_PAGES  = 1024,
    parameter int RAM_BYTES   = 1048576,
    parameter int PROC_SLOTS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [pma_pkg::BREAK_W-1:0]  cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  pma_pkg::cmd_t                cmd,
    input  logic [pma_pkg::PID_W-1:0]    proc_id,
    input  logic [pma_pkg::ADDR_W-1:0]   address,
    input  logic [pma_pkg::SIZE_W-1:0]   alloc_size,
    input  logic [pma_pkg::DATA_W-1:0]   write_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         status,
    output logic [pma_pkg::ADDR_W-1:0]   alloc_address,
    output logic [pma_pkg::DATA_W-1:0]   read_data
);

    import pma_pkg::*;

    // Derived geometry. RAM_BYTES and the page size are powers of two, so a
    // map entry sits at the concatenation of slot and virtual page number.
    localparam int PAGE_BYTES = 1 << OFFSET_BITS;
    localparam int VIRT_PAGES = RAM_BYTES >> OFFSET_BITS;
    localparam int VPN_W      = (VIRT_PAGES > 1) ? $clog2(VIRT_PAGES) : 1;
    localparam int SLOT_W     = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1;
    localparam int MAP_AW     = SLOT_W + VPN_W;
    localparam int MAP_DEPTH  = 1 << MAP_AW;
    localparam int PG_W       = (PHYS_PAGES > 1) ? $clog2(PHYS_PAGES) : 1;
    localparam int CNT_W      = $clog2(PHYS_PAGES + 1);
    localparam int BYTE_AW    = $clog2(RAM_BYTES);
    localparam int N_W        = SIZE_W + 1 - OFFSET_BITS;
    localparam int IVPN_W     = ADDR_W - OFFSET_BITS;
    localparam int CLR_A      = (MAP_DEPTH > RAM_BYTES) ? MAP_DEPTH : RAM_BYTES;
    localparam int CLR_LEN    = (CLR_A > PHYS_PAGES) ? CLR_A : PHYS_PAGES;
    localparam int CLR_W      = $clog2(CLR_LEN) + 1;

    // Sequencer states.
    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_LOOKUP   = 4'd3;
    localparam logic [3:0] S_SCAN_RD  = 4'd4;
    localparam logic [3:0] S_SCAN_CHK = 4'd5;
    localparam logic [3:0] S_SCAN_END = 4'd6;
    localparam logic [3:0] S_WALK_RD  = 4'd7;
    localparam logic [3:0] S_WALK_CHK = 4'd8;
    localparam logic [3:0] S_UNMAP    = 4'd9;
    localparam logic [3:0] S_BYTE     = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    // Control state.
    logic [3:0]         state_reg, state_next;
    logic [CLR_W-1:0]   clr_reg, clr_next;
    logic [BREAK_W-1:0] breaks_reg [PROC_SLOTS];
    logic [BREAK_W-1:0] breaks_next [PROC_SLOTS];
    logic [CNT_W-1:0]   free_cnt_reg, free_cnt_next;
    logic               out_valid_reg, out_valid_next;

    // Request and working registers (payload, no reset).
    cmd_t               cmd_reg, cmd_next;
    logic               pid_ok_reg, pid_ok_next;
    logic [PID_W-1:0]   pid_reg, pid_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [DATA_W-1:0]  wdata_reg, wdata_next;
    logic [N_W-1:0]     n_reg, n_next;
    logic [VPN_W-1:0]   vpn_base_reg, vpn_base_next;
    logic [PG_W-1:0]    idx_reg, idx_next;
    logic [N_W-1:0]     k_reg, k_next;
    logic [PG_W-1:0]    prev_reg, prev_next;
    logic               have_prev_reg, have_prev_next;
    logic [PG_W-1:0]    p_reg, p_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [IVPN_W-1:0]  vpn0_reg, vpn0_next;
    logic               res_status_reg, res_status_next;
    logic [ADDR_W-1:0]  res_aaddr_reg, res_aaddr_next;
    logic [DATA_W-1:0]  res_rdata_reg, res_rdata_next;
    logic               status_reg, status_next;
    logic [ADDR_W-1:0]  alloc_address_reg, alloc_address_next;
    logic [DATA_W-1:0]  read_data_reg, read_data_next;

    // RAM ports.
    logic               own_we;
    logic [PG_W-1:0]    own_waddr, own_raddr;
    logic [PID_W-1:0]   own_wdata, own_rdata;
    logic               lnk_we;
    logic [PG_W-1:0]    lnk_waddr;
    logic [PG_W:0]      lnk_wdata, lnk_rdata;
    logic               map_we;
    logic [MAP_AW-1:0]  map_waddr, map_raddr;
    logic [PG_W:0]      map_wdata, map_rdata;
    logic               byt_we;
    logic [BYTE_AW-1:0] byt_waddr, byt_raddr;
    logic [DATA_W-1:0]  byt_wdata, byt_rdata;

    // Helper values.
    logic               accept;
    logic [SIZE_W:0]    size_up;
    logic [SUM_W-1:0]   end_sum;
    logic [BREAK_W-1:0] cur_break;
    logic               vpn_oob;
    logic               map_hit;
    logic [PG_W-1:0]    map_page;
    logic [BYTE_AW-1:0] byte_addr;
    logic [SUM_W-1:0]   vpn_unmap;
    logic [N_W-1:0]     k_inc;
    logic [CNT_W-1:0]   cnt_inc;

    pma_ram #(.WIDTH(PID_W), .DEPTH(1 << PG_W)) u_owner_ram (
        .clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
        .raddr(own_raddr), .rdata(own_rdata)
    );

    pma_ram #(.WIDTH(PG_W + 1), .DEPTH(1 << PG_W)) u_link_ram (
        .clk(clk), .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
        .raddr(p_reg), .rdata(lnk_rdata)
    );

    pma_ram #(.WIDTH(PG_W + 1), .DEPTH(MAP_DEPTH)) u_map_ram (
        .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_rdata)
    );

    pma_ram #(.WIDTH(DATA_W), .DEPTH(1 << BYTE_AW)) u_byte_ram (
        .clk(clk), .we(byt_we), .waddr(byt_waddr), .wdata(byt_wdata),
        .raddr(byt_raddr), .rdata(byt_rdata)
    );

    assign in_ready      = (state_reg == S_IDLE);
    assign accept        = in_valid && in_ready;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign alloc_address = alloc_address_reg;
    assign read_data     = read_data_reg;

    // Request size rounded up to whole pages.
    assign size_up   = {1'b0, alloc_size} + (SIZE_W + 1)'(PAGE_BYTES - 1);
    assign cur_break = breaks_reg[slot_reg];
    assign end_sum   = SUM_W'(cur_break) + (SUM_W'(n_reg) << OFFSET_BITS);

    // Translation of the latched address; the map read is issued in DISPATCH
    // and its data is looked at in LOOKUP.
    assign map_raddr = {slot_reg, VPN_W'(addr_reg >> OFFSET_BITS)};
    assign vpn_oob   = SUM_W'(addr_reg >> OFFSET_BITS) >= SUM_W'(VIRT_PAGES);
    assign map_hit   = !vpn_oob && map_rdata[PG_W];
    assign map_page  = map_rdata[PG_W-1:0];
    assign byte_addr = (BYTE_AW'(map_page) << OFFSET_BITS)
                     | BYTE_AW'(addr_reg[OFFSET_BITS-1:0]);
    assign byt_raddr = byte_addr;

    // The owner RAM is read by the allocation scan and by the free walk.
    assign own_raddr = (state_reg == S_SCAN_RD) ? idx_reg : p_reg;

    assign vpn_unmap = SUM_W'(vpn0_reg) + SUM_W'(i_reg);
    assign k_inc     = k_reg + N_W'(1);
    assign cnt_inc   = cnt_reg + CNT_W'(1);

    always_comb
    begin
        state_next         = state_reg;
        clr_next           = clr_reg;
        breaks_next        = breaks_reg;
        free_cnt_next      = free_cnt_reg;
        out_valid_next     = out_valid_reg;
        cmd_next           = cmd_reg;
        pid_ok_next        = pid_ok_reg;
        pid_next           = pid_reg;
        slot_next          = slot_reg;
        addr_next          = addr_reg;
        wdata_next         = wdata_reg;
        n_next             = n_reg;
        vpn_base_next      = vpn_base_reg;
        idx_next           = idx_reg;
        k_next             = k_reg;
        prev_next          = prev_reg;
        have_prev_next     = have_prev_reg;
        p_next             = p_reg;
        cnt_next           = cnt_reg;
        i_next             = i_reg;
        vpn0_next          = vpn0_reg;
        res_status_next    = res_status_reg;
        res_aaddr_next     = res_aaddr_reg;
        res_rdata_next     = res_rdata_reg;
        status_next        = status_reg;
        alloc_address_next = alloc_address_reg;
        read_data_next     = read_data_reg;

        own_we    = 1'b0;
        own_waddr = idx_reg;
        own_wdata = pid_reg;
        lnk_we    = 1'b0;
        lnk_waddr = prev_reg;
        lnk_wdata = {1'b0, idx_reg};
        map_we    = 1'b0;
        map_waddr = {slot_reg, vpn_base_reg + VPN_W'(k_reg)};
        map_wdata = {1'b1, idx_reg};
        byt_we    = 1'b0;
        byt_waddr = byte_addr;
        byt_wdata = wdata_reg;

        // The result register drains independently of the sequencer.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                own_we    = clr_reg < CLR_W'(PHYS_PAGES);
                own_waddr = PG_W'(clr_reg);
                own_wdata = '0;
                lnk_we    = clr_reg < CLR_W'(PHYS_PAGES);
                lnk_waddr = PG_W'(clr_reg);
                lnk_wdata = '0;
                map_we    = clr_reg < CLR_W'(MAP_DEPTH);
                map_waddr = MAP_AW'(clr_reg);
                map_wdata = '0;
                byt_we    = clr_reg < CLR_W'(RAM_BYTES);
                byt_waddr = BYTE_AW'(clr_reg);
                byt_wdata = '0;
                clr_next  = clr_reg + CLR_W'(1);
                if (clr_reg == CLR_W'(CLR_LEN - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = cmd;
                    pid_next        = proc_id;
                    pid_ok_next     = (proc_id != '0) && (7'(proc_id) <= 7'(PROC_SLOTS));
                    slot_next       = SLOT_W'(proc_id - PID_W'(1));
                    addr_next       = address;
                    wdata_next      = write_data;
                    n_next          = N_W'(size_up >> OFFSET_BITS);
                    res_status_next = 1'b1;
                    res_aaddr_next  = '0;
                    res_rdata_next  = '0;
                    state_next      = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                if (!pid_ok_reg)
                begin
                    state_next = S_DONE;
                end
                else if (cmd_reg == CMD_ALLOC)
                begin
                    if (end_sum < SUM_W'(RAM_BYTES) && SUM_W'(free_cnt_reg) >= SUM_W'(n_reg))
                    begin
                        breaks_next[slot_reg] = BREAK_W'(end_sum);
                        vpn_base_next         = VPN_W'(cur_break >> OFFSET_BITS);
                        res_status_next       = 1'b0;
                        res_aaddr_next        = ADDR_W'(cur_break);
                        idx_next              = '0;
                        k_next                = '0;
                        have_prev_next        = 1'b0;
                        // A zero-size request maps nothing and keeps the break.
                        state_next            = (n_reg == '0) ? S_DONE : S_SCAN_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_LOOKUP;
                end
            end

            S_LOOKUP:
            begin
                if (cmd_reg == CMD_FREE)
                begin
                    if (map_hit)
                    begin
                        p_next     = map_page;
                        cnt_next   = '0;
                        vpn0_next  = IVPN_W'(addr_reg >> OFFSET_BITS);
                        state_next = S_WALK_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (map_hit && SUM_W'(map_page) < SUM_W'(VIRT_PAGES))
                begin
                    if (cmd_reg == CMD_WRITE)
                    begin
                        byt_we          = 1'b1;
                        res_status_next = 1'b0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_BYTE;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                if (own_rdata == '0)
                begin
                    // Claim this page, link it behind the previous one, map it.
                    own_we         = 1'b1;
                    lnk_we         = have_prev_reg;
                    map_we         = 1'b1;
                    k_next         = k_inc;
                    prev_next      = idx_reg;
                    have_prev_next = 1'b1;
                    free_cnt_next  = free_cnt_reg - CNT_W'(1);
                end
                if ((own_rdata == '0 && k_inc == n_reg) || idx_reg == PG_W'(PHYS_PAGES - 1))
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    idx_next   = idx_reg + PG_W'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_SCAN_END:
            begin
                // Mark the last claimed page as the end of the chain.
                lnk_we     = 1'b1;
                lnk_wdata  = {1'b1, PG_W'(0)};
                state_next = S_DONE;
            end

            S_WALK_RD:
            begin
                state_next = S_WALK_CHK;
            end

            S_WALK_CHK:
            begin
                // Pages met on the walk may already be free; count only real releases.
                own_we    = 1'b1;
                own_waddr = p_reg;
                own_wdata = '0;
                if (own_rdata != '0)
                begin
                    free_cnt_next = free_cnt_reg + CNT_W'(1);
                end
                cnt_next = cnt_inc;
                // Links only ever hold pages below PHYS_PAGES, so the walk
                // ends at an end mark or after PHYS_PAGES pages.
                if (lnk_rdata[PG_W] || cnt_inc == CNT_W'(PHYS_PAGES))
                begin
                    i_next     = '0;
                    state_next = S_UNMAP;
                end
                else
                begin
                    p_next     = lnk_rdata[PG_W-1:0];
                    state_next = S_WALK_RD;
                end
            end

            S_UNMAP:
            begin
                map_we    = vpn_unmap < SUM_W'(VIRT_PAGES);
                map_waddr = {slot_reg, VPN_W'(vpn_unmap)};
                map_wdata = '0;
                i_next    = i_reg + CNT_W'(1);
                if (i_reg + CNT_W'(1) == cnt_reg)
                begin
                    res_status_next = 1'b0;
                    state_next      = S_DONE;
                end
            end

            S_BYTE:
            begin
                res_rdata_next  = byt_rdata;
                res_status_next = 1'b0;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    status_next        = res_status_reg;
                    alloc_address_next = res_aaddr_reg;
                    read_data_next     = res_rdata_reg;
                    out_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Loading the break register resets the break of every process.
        if (cfg_we)
        begin
            for (int s = 0; s < PROC_SLOTS; s++)
            begin
                breaks_next[s] = cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            free_cnt_reg  <= CNT_W'(PHYS_PAGES);
            out_valid_reg <= 1'b0;
            for (int s = 0; s < PROC_SLOTS; s++)
            begin
                breaks_reg[s] <= BREAK_RESET;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_cnt_reg  <= free_cnt_next;
            out_valid_reg <= out_valid_next;
            breaks_reg    <= breaks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg           <= cmd_next;
        pid_ok_reg        <= pid_ok_next;
        pid_reg           <= pid_next;
        slot_reg          <= slot_next;
        addr_reg          <= addr_next;
        wdata_reg         <= wdata_next;
        n_reg             <= n_next;
        vpn_base_reg      <= vpn_base_next;
        idx_reg           <= idx_next;
        k_reg             <= k_next;
        prev_reg          <= prev_next;
        have_prev_reg     <= have_prev_next;
        p_reg             <= p_next;
        cnt_reg           <= cnt_next;
        i_reg             <= i_next;
        vpn0_reg          <= vpn0_next;
        res_status_reg    <= res_status_next;
        res_aaddr_reg     <= res_aaddr_next;
        res_rdata_reg     <= res_rdata_next;
        status_reg        <= status_next;
        alloc_address_reg <= alloc_address_next;
        read_data_reg     <= read_data_next;
    end

    `PMA_ASSERT(a_accept_dispatch, (in_valid && in_ready) |=> (state_reg == S_DISPATCH), "accepted request not dispatched")
    `PMA_ASSERT(a_scan_under_n, (state_reg == S_SCAN_CHK) |-> (k_reg < n_reg), "scan past requested page count")
    `PMA_ASSERT(a_walk_bounded, (state_reg == S_WALK_CHK) |-> (cnt_reg < CNT_W'(PHYS_PAGES)), "free walk exceeded page count")
    `PMA_ASSERT(a_unmap_bounded, (state_reg == S_UNMAP) |-> (i_reg < cnt_reg), "unmap past walked page count")
    `PMA_ASSERT(a_free_cnt_range, free_cnt_reg <= CNT_W'(PHYS_PAGES), "free page count out of range")

endmodule

### hw/rtl/pma_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
